// File: design/multi_stack_shared_array_core_macros.svh
// Assertion macros shared by the checker files of the multi-stack core.
// Needs a clk_i and an active-low rst_ni in the scope of the user.
`ifndef MULTI_STACK_SHARED_ARRAY_CORE_MACROS_SVH
`define MULTI_STACK_SHARED_ARRAY_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define MSA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define MSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/msa_pkg.sv
// Package of the multi-stack core: sizes, operation and status codes,
// and the control word passed from the controller to the datapath. No dependencies.
package msa_pkg;

  localparam int NUM_STACKS   = 3;
  localparam int REGION_DEPTH = 16;

  localparam int WORD_W  = 32;
  localparam int KIND_W  = 2;
  localparam int SEL_IN_W = 2;
  localparam int STAT_W  = 2;
  localparam int CAP_W   = 5;
  localparam int CAP_RESET = 16;

  localparam int MEM_DEPTH = NUM_STACKS * REGION_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int CNT_W     = $clog2(REGION_DEPTH + 1);
  localparam int SEL_W     = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_TOP  = 2'd2
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // Decision for one request: memory access and how to form the response.
  typedef struct packed {
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] addr;
    logic              ret_ones;
    status_e           status;
  } op_t;

endpackage

// File: design/msa_ifs.sv
// Request and response channel interfaces of the multi-stack core.
// Depends on msa_pkg for field widths.
interface msa_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [msa_pkg::KIND_W-1:0]           kind;
  logic [msa_pkg::SEL_IN_W-1:0]         stack_select;
  logic signed [msa_pkg::WORD_W-1:0]    push_value;

  modport source (output valid, kind, stack_select, push_value, input ready);
  modport sink   (input valid, kind, stack_select, push_value, output ready);
endinterface

interface msa_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [msa_pkg::WORD_W-1:0]    read_value;
  logic [msa_pkg::STAT_W-1:0]           status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

// File: design/msa_ram.sv
// Generic single-port synchronous RAM with registered read.
// No package dependencies.
module msa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 48
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/msa_ctrl.sv
// Fill-count bank and operation decode for the multi-stack core.
// Depends on msa_pkg.
module msa_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [msa_pkg::KIND_W-1:0]    kind_i,
  input  logic [msa_pkg::SEL_IN_W-1:0]  stack_select_i,
  input  logic [msa_pkg::CAP_W-1:0]     capacity_i,
  output msa_pkg::op_t                  op_o
);

  logic [msa_pkg::CNT_W-1:0]  fill_q [msa_pkg::NUM_STACKS];
  logic [msa_pkg::CNT_W-1:0]  fill_d;
  logic [msa_pkg::SEL_W-1:0]  sel;
  logic                       sel_ok;
  logic [msa_pkg::CNT_W-1:0]  fill;
  logic                       full;
  logic [msa_pkg::ADDR_W-1:0] base;
  logic                       upd;

  assign sel_ok = 32'(stack_select_i) < msa_pkg::NUM_STACKS;
  assign sel    = msa_pkg::SEL_W'(stack_select_i);
  assign fill   = sel_ok ? fill_q[sel] : '0;
  // Full against the smaller of the register and the region size.
  assign full   = (32'(fill) >= 32'(capacity_i)) || (32'(fill) >= msa_pkg::REGION_DEPTH);
  assign base   = msa_pkg::ADDR_W'(32'(sel) * msa_pkg::REGION_DEPTH);

  always_comb begin
    op_o          = '0;
    op_o.status   = msa_pkg::STATUS_OK;
    fill_d        = fill;
    upd           = 1'b0;
    case (msa_pkg::kind_e'(kind_i))
      msa_pkg::KIND_PUSH: begin
        if (!sel_ok || full) begin
          op_o.status = msa_pkg::STATUS_FULL;
        end else begin
          op_o.mem_we = 1'b1;
          op_o.addr   = base + msa_pkg::ADDR_W'(fill);
          fill_d      = fill + msa_pkg::CNT_W'(1);
          upd         = 1'b1;
        end
      end
      msa_pkg::KIND_POP, msa_pkg::KIND_TOP: begin
        if (!sel_ok || fill == '0) begin
          op_o.status   = msa_pkg::STATUS_EMPTY;
          op_o.ret_ones = 1'b1;
        end else begin
          op_o.mem_re = 1'b1;
          op_o.addr   = base + msa_pkg::ADDR_W'(fill - msa_pkg::CNT_W'(1));
          if (msa_pkg::kind_e'(kind_i) == msa_pkg::KIND_POP) begin
            fill_d = fill - msa_pkg::CNT_W'(1);
            upd    = 1'b1;
          end
        end
      end
      default: begin
        op_o.status = msa_pkg::STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < msa_pkg::NUM_STACKS; i++) begin
        fill_q[i] <= '0;
      end
    end else if (accept_i && upd) begin
      fill_q[sel] <= fill_d;
    end
  end

endmodule

// File: design/multi_stack_shared_array_core.sv
// Top level of the fixed-partition multi-stack core: config register,
// response register and the shared entry RAM. Depends on msa_pkg, msa_ifs,
// msa_ctrl and msa_ram.
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+-----------------------------------
//  req       | in  | valid / ready    | kind, stack_select, push_value
//  rsp       | out | valid / ready    | read_value, status
//  cfg       | in  | cfg_we_i only    | cfg_wdata_i = capacity_per_stack
//
//  Each request is handled in order: on accept, fill counts are
//  checked and updated and the RAM access is issued; then, while busy,
//  the registered RAM read is loaded into the response register.
//  A new request is taken while the previous response is being drained.
//  Reset clears fill counts and handshake state, capacity returns to 16;
//  the entry RAM is not cleared (only written slots are ever read).
//  A stalled response holds its register and blocks further requests.
module multi_stack_shared_array_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  msa_req_if.sink                     req,
  msa_rsp_if.source                   rsp,
  input  logic                        cfg_we_i,
  input  logic [msa_pkg::CAP_W-1:0]   cfg_wdata_i
);

  logic [msa_pkg::CAP_W-1:0]  capacity_q;
  logic                       accept;
  msa_pkg::op_t               op;
  logic [msa_pkg::WORD_W-1:0] rdata;

  // Pending request between issue and response.
  logic                       busy_q;
  logic                       use_rdata_q;
  logic                       ret_ones_q;
  msa_pkg::status_e           status_q;

  // Response register.
  logic                       rsp_valid_q, rsp_valid_d;
  logic [msa_pkg::WORD_W-1:0] rsp_value_q;
  msa_pkg::status_e           rsp_status_q;

  // Only one request in flight; the response slot must be free or draining.
  assign req.ready = !busy_q && (!rsp_valid_q || rsp.ready);
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= msa_pkg::CAP_W'(msa_pkg::CAP_RESET);
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  msa_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .kind_i         (req.kind),
    .stack_select_i (req.stack_select),
    .capacity_i     (capacity_q),
    .op_o           (op)
  );

  msa_ram #(
    .WIDTH (msa_pkg::WORD_W),
    .DEPTH (msa_pkg::MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (accept && (op.mem_we || op.mem_re)),
    .we_i    (op.mem_we),
    .addr_i  (op.addr),
    .wdata_i (req.push_value),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      use_rdata_q <= op.mem_re;
      ret_ones_q  <= op.ret_ones;
      status_q    <= op.status;
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (busy_q) begin
      rsp_valid_d = 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Pop or top with data answers the RAM word, empty answers all ones, push and unknown kinds answer zero.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rsp_status_q <= status_q;
      if (use_rdata_q) begin
        rsp_value_q <= rdata;
      end else if (ret_ones_q) begin
        rsp_value_q <= '1;
      end else begin
        rsp_value_q <= '0;
      end
    end
  end

  assign rsp.valid      = rsp_valid_q;
  assign rsp.read_value = rsp_value_q;
  assign rsp.status     = rsp_status_q;

endmodule

// File: design/msa_chk.sv
// Port-level checker for the multi-stack core, bound to the top level.
// Depends on msa_pkg and the assertion macro header.
`include "multi_stack_shared_array_core_macros.svh"

module msa_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic [msa_pkg::WORD_W-1:0]  rsp_value_i,
  input logic [msa_pkg::STAT_W-1:0]  rsp_status_i
);

  `MSA_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_value_i), "stalled response changed")
  `MSA_ASSERT_NEXT(a_one_in_flight, req_valid_i && req_ready_i, !req_ready_i && !rsp_valid_i, "request taken while busy")
  `MSA_ASSERT_NEXT(a_rsp_follows, req_valid_i && req_ready_i, ##1 rsp_valid_i, "response missing after request")
  `MSA_ASSERT_SAME(a_full_zero, rsp_valid_i && rsp_status_i == msa_pkg::STATUS_FULL, rsp_value_i == '0, "full response not zero")
  `MSA_ASSERT_SAME(a_empty_ones, rsp_valid_i && rsp_status_i == msa_pkg::STATUS_EMPTY, rsp_value_i == '1, "empty response not all ones")

endmodule

bind multi_stack_shared_array_core msa_chk u_msa_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req.valid),
  .req_ready_i  (req.ready),
  .rsp_valid_i  (rsp.valid),
  .rsp_ready_i  (rsp.ready),
  .rsp_value_i  (rsp.read_value),
  .rsp_status_i (rsp.status)
);
